FILE: rtl/core/tpsm_pkg.sv
package tpsm_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int TIME_W     = 16;
    localparam int ELAPSED_W  = 8;
    localparam int BTN_W      = 3;
    localparam int PHASE_W    = 3;

    typedef enum logic [1:0] {
        MODE_STEADY = 2'd0,
        MODE_SIMPLE = 2'd1,
        MODE_FULL   = 2'd2
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIME  = 2'd2;

    localparam logic [TIME_W-1:0] PRESS_TIME_RST = 16'd100;
    localparam logic [TIME_W-1:0] IDLE_TIME_RST  = 16'd100;

    // Switch positions
    localparam logic [1:0] POS_ONE   = 2'd1;
    localparam logic [1:0] POS_TWO   = 2'd2;
    localparam logic [1:0] POS_THREE = 2'd3;

    // Phase codes: bit 2 = idle; low bits = position, less one if idle
    localparam logic [PHASE_W-1:0] PH_NONE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PRESS2 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PRESS3 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_IDLE1  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_IDLE2  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_IDLE3  = 3'd6;

    typedef struct packed {
        mode_t             mode;
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] idle_time;
    } cfg_t;

    typedef struct packed {
        logic                 pin_one_low;
        logic                 pin_two_low;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } item_t;

    // One-hot button pattern of a position; zero for no position
    function automatic logic [BTN_W-1:0] pos_bits(input logic [1:0] pos);
        logic [BTN_W-1:0] bits;
        begin
            case (pos)
                POS_ONE:   bits = 3'b001;
                POS_TWO:   bits = 3'b010;
                POS_THREE: bits = 3'b100;
                default:   bits = 3'b000;
            endcase
            return bits;
        end
    endfunction

endpackage

FILE: rtl/core/tpsm_cfg.sv
module tpsm_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tpsm_pkg::cfg_t                      cfg
);
    import tpsm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= MODE_STEADY;
            cfg_reg.press_time <= PRESS_TIME_RST;
            cfg_reg.idle_time  <= IDLE_TIME_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:       cfg_reg.mode       <= mode_t'(cfg_data[1:0]);
                CFG_PRESS_TIME: cfg_reg.press_time <= cfg_data[TIME_W-1:0];
                CFG_IDLE_TIME:  cfg_reg.idle_time  <= cfg_data[TIME_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/tpsm_in_stage.sv
module tpsm_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tpsm_pkg::item_t item_in,
    input  logic            take,
    output logic            s1_valid,
    output tpsm_pkg::item_t s1_item
);
    import tpsm_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Accept a new beat whenever empty or the held one leaves in this cycle
    assign in_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

FILE: rtl/core/tpsm_ctrl.sv
module tpsm_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tpsm_pkg::cfg_t                 cfg,
    input  logic                           step,
    input  tpsm_pkg::item_t                item,
    output logic [tpsm_pkg::BTN_W-1:0]     held_next
);
    import tpsm_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TIME_W-1:0]  rem_reg, rem_next;
    logic [BTN_W-1:0]   held_reg;

    logic [1:0]         pos;
    logic [BTN_W-1:0]   cur_bits;
    logic               running;
    logic [TIME_W-1:0]  rem_dec;

    always_comb
    begin
        if (item.pin_one_low)
            pos = POS_ONE;
        else if (item.pin_two_low)
            pos = POS_THREE;
        else
            pos = POS_TWO;
    end

    assign cur_bits = pos_bits(pos);
    assign running  = rem_reg > {{(TIME_W-ELAPSED_W){1'b0}}, item.elapsed_ms};
    assign rem_dec  = rem_reg - {{(TIME_W-ELAPSED_W){1'b0}}, item.elapsed_ms};

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        held_next  = held_reg;
        case (cfg.mode)
            MODE_STEADY:
            begin
                held_next = cur_bits;
            end
            MODE_SIMPLE:
            begin
                if (phase_reg != {1'b0, pos})
                begin
                    phase_next = {1'b0, pos};
                    rem_next   = cfg.press_time;
                    held_next  = cur_bits;
                end
                else if (running)
                begin
                    rem_next  = rem_dec;
                    held_next = cur_bits;
                end
                else
                begin
                    rem_next  = '0;
                    held_next = '0;
                end
            end
            MODE_FULL:
            begin
                if (phase_reg[2])
                begin
                    // Idle phase: start a new press once idle ends on a new position
                    if (running)
                    begin
                        rem_next  = rem_dec;
                        held_next = '0;
                    end
                    else if (phase_reg != ({1'b0, pos} + PH_PRESS3))
                    begin
                        phase_next = {1'b0, pos};
                        rem_next   = cfg.press_time;
                    end
                    else
                    begin
                        rem_next = '0;
                    end
                end
                else if (running)
                begin
                    rem_next  = rem_dec;
                    held_next = pos_bits(phase_reg[1:0]);
                end
                else
                begin
                    held_next = '0;
                    rem_next  = cfg.idle_time;
                    case (phase_reg)
                        PH_PRESS2: phase_next = PH_IDLE2;
                        PH_PRESS3: phase_next = PH_IDLE3;
                        default:   phase_next = PH_IDLE1;
                    endcase
                end
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NONE;
            rem_reg   <= '0;
            held_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            held_reg  <= held_next;
        end
    end

endmodule

FILE: rtl/core/tpsm_out_stage.sv
module tpsm_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s1_valid,
    input  logic [tpsm_pkg::BTN_W-1:0]  buttons_in,
    output logic                        take,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tpsm_pkg::BTN_W-1:0]  buttons
);
    import tpsm_pkg::*;

    logic             valid_reg;
    logic [BTN_W-1:0] buttons_reg;
    logic             free;

    // Result register is free when empty or being drained this cycle
    assign free = !valid_reg || out_ready;
    assign take = s1_valid && free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buttons_reg <= buttons_in;
        end
    end

    assign out_valid = valid_reg;
    assign buttons   = buttons_reg;

endmodule

FILE: rtl/core/three_position_switch_momentary_top.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    pin_one_low, pin_two_low, elapsed_ms
// out       out_valid / out_ready  button_one_on, button_two_on, button_three_on
// cfg       cfg_we                 cfg_index, cfg_data
//
// One tick per cycle sustained while out_ready is high; a result passes the input
// register, then the state update and the result register.
// Reset clears valids, state (no phase, zero count, buttons off) and loads
// register defaults: steady mode, 100 ms press and idle.
// A stalled output holds the result register; the input register takes a new
// beat in the same cycle the held one moves on.
module three_position_switch_momentary_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                pin_one_low,
    input  logic                                pin_two_low,
    input  logic [tpsm_pkg::ELAPSED_W-1:0]      elapsed_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                button_one_on,
    output logic                                button_two_on,
    output logic                                button_three_on,
    input  logic                                cfg_we,
    input  logic [tpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tpsm_pkg::*;

    cfg_t             cfg;
    item_t            item_in;
    item_t            s1_item;
    logic             s1_valid;
    logic             take;
    logic [BTN_W-1:0] held_next;
    logic [BTN_W-1:0] buttons;

    assign item_in.pin_one_low = pin_one_low;
    assign item_in.pin_two_low = pin_two_low;
    assign item_in.elapsed_ms  = elapsed_ms;

    tpsm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpsm_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .item_in  (item_in),
        .take     (take),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    tpsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (take),
        .item      (s1_item),
        .held_next (held_next)
    );

    tpsm_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .buttons_in (held_next),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .buttons    (buttons)
    );

    assign button_one_on   = buttons[0];
    assign button_two_on   = buttons[1];
    assign button_three_on = buttons[2];

endmodule
